FILE: design/nws_pkg.sv
package nws_pkg;

   localparam int TableDepth = 1024;
   localparam int AddrWidth  = 10;
   localparam int CountWidth = 11;
   localparam int MaxWindow  = 64;
   localparam int CoordWidth = 24;
   localparam int SpeedWidth = 16;
   localparam int DistWidth  = 51;

   localparam logic [1:0] ACT_CLEAR   = 2'd0;
   localparam logic [1:0] ACT_APPEND  = 2'd1;
   localparam logic [1:0] ACT_NEAREST = 2'd2;
   localparam logic [1:0] ACT_FETCH   = 2'd3;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;

   typedef struct packed {
      logic       load;
      logic       clear;
      logic       write;
      logic       mod_step;
      logic       read;
      logic       read_next;
      logic       cmp;
      logic       result_load;
      logic [1:0] result_kind;
      logic       result_last;
   } nws_cmd_type;

   localparam logic [1:0] RES_PLAIN   = 2'd0;
   localparam logic [1:0] RES_ENTRY   = 2'd1;
   localparam logic [1:0] RES_NEAREST = 2'd2;

   typedef struct packed {
      logic [1:0]            action;
      logic                  empty;
      logic                  full;
      logic                  mod_done;
      logic                  scan_end;
      logic                  fetch_end;
   } nws_stat_type;

endpackage

FILE: design/nws_datapath.sv
module nws_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  nws_pkg::nws_cmd_type                  cmd,
   output nws_pkg::nws_stat_type                 stat,
   input  logic [1:0]                            in_action,
   input  logic signed [nws_pkg::CoordWidth-1:0] in_x,
   input  logic signed [nws_pkg::CoordWidth-1:0] in_y,
   input  logic [nws_pkg::SpeedWidth-1:0]        in_speed,
   input  logic signed [15:0]                    in_start,
   input  logic [6:0]                            in_count,
   output logic [1:0]                            res_status,
   output logic [9:0]                            res_index,
   output logic [nws_pkg::CoordWidth-1:0]        res_x,
   output logic [nws_pkg::CoordWidth-1:0]        res_y,
   output logic [nws_pkg::SpeedWidth-1:0]        res_speed,
   output logic [nws_pkg::DistWidth-1:0]         res_dist,
   output logic                                  res_last
);

   localparam int AW = nws_pkg::AddrWidth;
   localparam int CW = nws_pkg::CountWidth;
   localparam int XW = nws_pkg::CoordWidth;
   localparam int SW = nws_pkg::SpeedWidth;
   localparam int DW = nws_pkg::DistWidth;

   logic [XW-1:0] mem_x [nws_pkg::TableDepth];
   logic [XW-1:0] mem_y [nws_pkg::TableDepth];
   logic [SW-1:0] mem_s [nws_pkg::TableDepth];

   logic [CW-1:0] count_ff, count_in;
   logic [1:0]    action_ff;
   logic signed [XW-1:0] qx_ff, qy_ff, wx_ff, wy_ff;
   logic [SW-1:0] ws_ff;
   logic [6:0]    left_ff, left_in;
   // start index reduced by add or subtract steps: held as 18-bit signed residue
   logic signed [17:0] rem_ff, rem_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [AW-1:0] rd_addr_ff;
   logic [XW-1:0] rx_ff, ry_ff;
   logic [SW-1:0] rs_ff;
   logic          rd_valid_ff;
   logic signed [XW:0] dx_ff, dy_ff;
   logic [AW-1:0] dv_addr_ff, sq_addr_ff;
   logic [XW-1:0] dv_x_ff, dv_y_ff, sq_x_ff, sq_y_ff;
   logic [SW-1:0] dv_s_ff, sq_s_ff;
   logic          dv_valid_ff, sq_valid_ff;
   logic [DW-2:0] sqx_ff, sqy_ff;
   logic [DW-1:0] best_d_ff;
   logic [AW-1:0] best_i_ff;
   logic [XW-1:0] best_x_ff, best_y_ff;
   logic [SW-1:0] best_s_ff;
   logic          best_set_ff;
   logic [DW-1:0] d_sum;
   logic [6:0]    cnt_clip;
   logic [17:0]   cnt_ext;

   assign cnt_clip = (in_count == 7'd0) ? 7'd1 :
                     (in_count > 7'(nws_pkg::MaxWindow)) ? 7'(nws_pkg::MaxWindow) : in_count;
   assign cnt_ext  = {7'd0, count_ff};

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.write) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         mem_x[count_ff[AW-1:0]] <= wx_ff;
         mem_y[count_ff[AW-1:0]] <= wy_ff;
         mem_s[count_ff[AW-1:0]] <= ws_ff;
      end
      rx_ff <= mem_x[rd_addr_ff];
      ry_ff <= mem_y[rd_addr_ff];
      rs_ff <= mem_s[rd_addr_ff];
   end

   always_comb begin
      rem_in  = rem_ff;
      addr_in = addr_ff;
      left_in = left_ff;
      if (cmd.load) begin
         rem_in  = 18'(in_start);
         addr_in = '0;
         left_in = cnt_clip;
      end else if (cmd.mod_step) begin
         // one add or subtract of the entry count per cycle
         if (rem_ff < 0) begin
            rem_in = rem_ff + $signed(cnt_ext);
         end else begin
            rem_in = rem_ff - $signed(cnt_ext);
         end
         if (rem_ff >= 0 && rem_ff < $signed(cnt_ext)) begin
            rem_in  = rem_ff;
            addr_in = rem_ff[AW-1:0];
         end
      end else if (cmd.read_next) begin
         addr_in = (CW'(addr_ff) + 1'b1 == count_ff) ? '0 : addr_ff + 1'b1;
         left_in = left_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= in_action;
         qx_ff     <= in_x;
         qy_ff     <= in_y;
         wx_ff     <= in_x;
         wy_ff     <= in_y;
         ws_ff     <= in_speed;
      end
      rem_ff     <= rem_in;
      addr_ff    <= addr_in;
      left_ff    <= left_in;
      rd_addr_ff <= addr_in;
   end

   // compare pipeline: read, difference, square, compare
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
         dv_valid_ff <= 1'b0;
         sq_valid_ff <= 1'b0;
         best_set_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.read && cmd.cmp;
         dv_valid_ff <= rd_valid_ff;
         sq_valid_ff <= dv_valid_ff;
         if (cmd.load) begin
            best_set_ff <= 1'b0;
         end else if (sq_valid_ff) begin
            best_set_ff <= 1'b1;
         end
      end
   end

   logic [AW-1:0] rd_tag_ff;
   always_ff @(posedge clock) begin
      rd_tag_ff  <= rd_addr_ff;
      dx_ff      <= $signed({rx_ff[XW-1], rx_ff}) - $signed({qx_ff[XW-1], qx_ff});
      dy_ff      <= $signed({ry_ff[XW-1], ry_ff}) - $signed({qy_ff[XW-1], qy_ff});
      dv_addr_ff <= rd_tag_ff;
      dv_x_ff    <= rx_ff;
      dv_y_ff    <= ry_ff;
      dv_s_ff    <= rs_ff;
      sqx_ff     <= (DW-1)'(dx_ff * dx_ff);
      sqy_ff     <= (DW-1)'(dy_ff * dy_ff);
      sq_addr_ff <= dv_addr_ff;
      sq_x_ff    <= dv_x_ff;
      sq_y_ff    <= dv_y_ff;
      sq_s_ff    <= dv_s_ff;
   end

   assign d_sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   always_ff @(posedge clock) begin
      if (sq_valid_ff && (!best_set_ff || d_sum < best_d_ff)) begin
         best_d_ff <= d_sum;
         best_i_ff <= sq_addr_ff;
         best_x_ff <= sq_x_ff;
         best_y_ff <= sq_y_ff;
         best_s_ff <= sq_s_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         res_last   <= cmd.result_last;
         res_status <= nws_pkg::STAT_OK;
         res_index  <= '0;
         res_x      <= '0;
         res_y      <= '0;
         res_speed  <= '0;
         res_dist   <= '0;
         case (cmd.result_kind)
            nws_pkg::RES_ENTRY: begin
               if (action_ff == nws_pkg::ACT_APPEND) begin
                  res_index <= count_ff[AW-1:0];
                  res_x     <= wx_ff;
                  res_y     <= wy_ff;
                  res_speed <= ws_ff;
               end else begin
                  res_index <= rd_tag_ff;
                  res_x     <= rx_ff;
                  res_y     <= ry_ff;
                  res_speed <= rs_ff;
               end
            end
            nws_pkg::RES_NEAREST: begin
               res_index <= best_i_ff;
               res_x     <= best_x_ff;
               res_y     <= best_y_ff;
               res_speed <= best_s_ff;
               res_dist  <= best_d_ff;
            end
            default: begin
               if (action_ff == nws_pkg::ACT_APPEND) begin
                  res_status <= nws_pkg::STAT_FULL;
               end else if (action_ff != nws_pkg::ACT_CLEAR) begin
                  res_status <= nws_pkg::STAT_EMPTY;
               end
            end
         endcase
      end
   end

   assign stat.action    = action_ff;
   assign stat.empty     = (count_ff == '0);
   assign stat.full      = (count_ff >= CW'(nws_pkg::TableDepth));
   assign stat.mod_done  = (rem_ff >= 0) && (rem_ff < $signed(cnt_ext));
   assign stat.scan_end  = (CW'(addr_ff) + 1'b1 == count_ff);
   assign stat.fetch_end = (left_ff == 7'd1);

endmodule

FILE: design/nws_control.sv
module nws_control (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_fire,
   output logic                  busy,
   input  logic                  rsp_free,
   output logic                  rsp_set,
   input  nws_pkg::nws_stat_type stat,
   output nws_pkg::nws_cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DISP  = 3'd1;
   localparam logic [2:0] ST_MOD   = 3'd2;
   localparam logic [2:0] ST_SCAN  = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;
   localparam logic [2:0] ST_FRD   = 3'd5;
   localparam logic [2:0] ST_FOUT  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [2:0] wait_ff, wait_in;

   always_comb begin
      state_in = state_ff;
      wait_in  = wait_ff;
      cmd      = '0;
      rsp_set  = 1'b0;
      cmd.load = req_fire;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_DISP;
            end
         end
         ST_DISP: begin
            if (rsp_free) begin
               case (stat.action)
                  nws_pkg::ACT_CLEAR: begin
                     cmd.clear = 1'b1;
                     cmd.result_load = 1'b1;
                     cmd.result_last = 1'b1;
                     rsp_set = 1'b1;
                     state_in = ST_IDLE;
                  end
                  nws_pkg::ACT_APPEND: begin
                     cmd.result_load = 1'b1;
                     cmd.result_last = 1'b1;
                     cmd.result_kind = stat.full ? nws_pkg::RES_PLAIN : nws_pkg::RES_ENTRY;
                     cmd.write = !stat.full;
                     rsp_set = 1'b1;
                     state_in = ST_IDLE;
                  end
                  default: begin
                     if (stat.empty) begin
                        cmd.result_load = 1'b1;
                        cmd.result_last = 1'b1;
                        rsp_set = 1'b1;
                        state_in = ST_IDLE;
                     end else if (stat.action == nws_pkg::ACT_NEAREST) begin
                        state_in = ST_SCAN;
                     end else begin
                        state_in = ST_MOD;
                     end
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // read the current address; advance until the last stored entry
            cmd.read = 1'b1;
            cmd.cmp  = 1'b1;
            if (stat.scan_end) begin
               state_in = ST_DRAIN;
               wait_in  = 3'd4;
            end else begin
               cmd.read_next = 1'b1;
            end
         end
         ST_DRAIN: begin
            if (wait_ff == 3'd0) begin
               if (rsp_free) begin
                  cmd.result_load = 1'b1;
                  cmd.result_kind = nws_pkg::RES_NEAREST;
                  cmd.result_last = 1'b1;
                  rsp_set = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               wait_in = wait_ff - 1'b1;
            end
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
            if (stat.mod_done) begin
               state_in = ST_FRD;
            end
         end
         ST_FRD: begin
            state_in = ST_FOUT;
         end
         ST_FOUT: begin
            if (rsp_free) begin
               cmd.result_load = 1'b1;
               cmd.result_kind = nws_pkg::RES_ENTRY;
               cmd.result_last = stat.fetch_end;
               rsp_set = 1'b1;
               if (stat.fetch_end) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.read_next = 1'b1;
                  state_in = ST_FRD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wait_ff  <= '0;
      end else begin
         state_ff <= state_in;
         wait_ff  <= wait_in;
      end
   end

   ctl_load_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> state_ff == ST_IDLE)
      else $error("request taken while busy");
   ctl_set_free: assert property (@(posedge clock) disable iff (reset)
      rsp_set |-> rsp_free)
      else $error("result loaded over pending result");
   ctl_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_set && cmd.result_last) |=> state_ff == ST_IDLE)
      else $error("last result without return to idle");

endmodule

FILE: design/nearest_waypoint_search_top.sv
// channel | dir | tdata fields (low bit up)                                  | tuser
// req     | in  | pos_x 24, pos_y 24, speed 16, start_index 16, point_count 7 | action 2
// rsp     | out | entry_index 10, out_x 24, out_y 24, out_speed 16, dist 51   | status 2; tlast
// Nearest query: one stored entry per cycle through the single table read port.
// Fetch: the start wrap uses add/subtract steps of the entry count, then each
// waypoint goes through a table read, then the output register.
// Reset clears the entry count and handshakes; table contents are kept.
// rsp_tready low holds the result; one request is in flight at a time.
module nearest_waypoint_search_top (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [87:0]   req_tdata,  // pos_x, pos_y, speed, start_index, point_count
   input  logic [1:0]    req_tuser,  // action
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [127:0]  rsp_tdata,  // entry_index, out_x, out_y, out_speed, dist_squared
   output logic [1:0]    rsp_tuser,  // status
   output logic          rsp_tlast
);

   nws_pkg::nws_cmd_type  cmd;
   nws_pkg::nws_stat_type stat;
   logic busy, rsp_set, req_fire, rsp_valid_ff;
   logic [9:0]  r_index;
   logic [23:0] r_x, r_y;
   logic [15:0] r_speed;
   logic [50:0] r_dist;

   assign req_tready = !busy;
   assign req_fire   = req_tvalid && req_tready;

   nws_control u_ctl (
      .clock(clock), .reset(reset), .req_fire(req_fire), .busy(busy),
      .rsp_free(!rsp_valid_ff || rsp_tready), .rsp_set(rsp_set),
      .stat(stat), .cmd(cmd)
   );

   nws_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .in_action(req_tuser),
      .in_x(req_tdata[23:0]), .in_y(req_tdata[47:24]),
      .in_speed(req_tdata[63:48]), .in_start(req_tdata[79:64]),
      .in_count(req_tdata[86:80]),
      .res_status(rsp_tuser), .res_index(r_index), .res_x(r_x), .res_y(r_y),
      .res_speed(r_speed), .res_dist(r_dist), .res_last(rsp_tlast)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_set) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, r_dist, r_speed, r_y, r_x, r_index};

endmodule
